### src/sct_pkg.sv
// Shared types, token codes and character classification for the source tokenizer.
package sct_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LENGTH_DEF    = 255;
    localparam int POSITION_BITS_DEF = 16;

    // Result queue depth (two free entries are needed per input beat)
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Character codes with a role of their own
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [4:0] {
        KIND_IDENT    = 5'd0,
        KIND_NUMBER   = 5'd1,
        KIND_STRING   = 5'd2,
        KIND_PLUS     = 5'd3,
        KIND_MINUS    = 5'd4,
        KIND_STAR     = 5'd5,
        KIND_SLASH    = 5'd6,
        KIND_ASSIGN   = 5'd7,
        KIND_EQ       = 5'd8,
        KIND_NE       = 5'd9,
        KIND_LT       = 5'd10,
        KIND_LE       = 5'd11,
        KIND_GT       = 5'd12,
        KIND_GE       = 5'd13,
        KIND_AND      = 5'd14,
        KIND_OR       = 5'd15,
        KIND_LPAREN   = 5'd16,
        KIND_RPAREN   = 5'd17,
        KIND_LBRACE   = 5'd18,
        KIND_RBRACE   = 5'd19,
        KIND_COMMA    = 5'd20,
        KIND_SEMI     = 5'd21,
        KIND_IF       = 5'd22,
        KIND_ELSE     = 5'd23,
        KIND_WHILE    = 5'd24,
        KIND_FUNCTION = 5'd25,
        KIND_VAR      = 5'd26,
        KIND_PRINTF   = 5'd27,
        KIND_RETURN   = 5'd28,
        KIND_END      = 5'd29,
        KIND_ERROR    = 5'd30
    } token_kind_t;

    // First eight characters of a token, byte 0 first
    typedef logic [7:0][7:0] head_t;

    typedef struct packed {
        token_kind_t kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  length;
        logic        last;
    } token_t;

    // Up to two tokens produced by one input beat
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["A":"Z"], ["a":"z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]});
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    endfunction

    // Brackets and semicolon never start a greedy run
    function automatic logic is_bracket(input logic [7:0] c);
        return (c == "(") || (c == ")") || (c == "{") || (c == "}") || (c == ";");
    endfunction

    // Operator lookup for a one- or two-character run
    function automatic token_kind_t special_kind(input logic [7:0] h0, input logic [7:0] h1,
                                                 input logic one, input logic two);
        token_kind_t k;
        k = KIND_ERROR;
        if (one) begin
            case (h0)
                "+":     k = KIND_PLUS;
                "-":     k = KIND_MINUS;
                "*":     k = KIND_STAR;
                "/":     k = KIND_SLASH;
                "=":     k = KIND_ASSIGN;
                "<":     k = KIND_LT;
                ">":     k = KIND_GT;
                "(":     k = KIND_LPAREN;
                ")":     k = KIND_RPAREN;
                "{":     k = KIND_LBRACE;
                "}":     k = KIND_RBRACE;
                ",":     k = KIND_COMMA;
                ";":     k = KIND_SEMI;
                default: k = KIND_ERROR;
            endcase
        end else if (two) begin
            if ({h0, h1} == "==") k = KIND_EQ;
            else if ({h0, h1} == "!=") k = KIND_NE;
            else if ({h0, h1} == "<=") k = KIND_LE;
            else if ({h0, h1} == ">=") k = KIND_GE;
            else if ({h0, h1} == "&&") k = KIND_AND;
            else if ({h0, h1} == "||") k = KIND_OR;
        end
        return k;
    endfunction

    // Keyword check; n is the token length, any value above eight never matches
    function automatic token_kind_t keyword_kind(input head_t h, input logic [3:0] n);
        token_kind_t k;
        k = KIND_IDENT;
        if (n == 4'd2 && {h[0], h[1]} == "if")
            k = KIND_IF;
        else if (n == 4'd4 && {h[0], h[1], h[2], h[3]} == "else")
            k = KIND_ELSE;
        else if (n == 4'd5 && {h[0], h[1], h[2], h[3], h[4]} == "while")
            k = KIND_WHILE;
        else if (n == 4'd8 && {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]} == "function")
            k = KIND_FUNCTION;
        else if (n == 4'd3 && {h[0], h[1], h[2]} == "var")
            k = KIND_VAR;
        else if (n == 4'd6 && {h[0], h[1], h[2], h[3], h[4], h[5]} == "printf")
            k = KIND_PRINTF;
        else if (n == 4'd6 && {h[0], h[1], h[2], h[3], h[4], h[5]} == "return")
            k = KIND_RETURN;
        return k;
    endfunction

endpackage

### src/sct_if.sv
// Valid/ready channel interfaces for source characters and tokens.
interface sct_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_input;

    modport source (output valid, output character, output end_of_input, input ready);
    modport sink (input valid, input character, input end_of_input, output ready);
endinterface

interface sct_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_line, output start_column,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_line, input start_column,
                  input token_length, input last_of_run, output ready);
endinterface

### src/sct_lexer.sv
// Character input register, tokenizer state and per-character token logic.
module sct_lexer
    import sct_pkg::*;
#(
    parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sct_char_if.sink    chars,
    input  logic        room,
    output push_t       push
);

    localparam int LW      = $clog2(MAX_LENGTH + 2);
    localparam int LEN_LIM = (MAX_LENGTH < 255) ? MAX_LENGTH : 255;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_IDENT  = 5'b00010,
        MODE_NUMBER = 5'b00100,
        MODE_STRING = 5'b01000,
        MODE_RUN    = 5'b10000
    } mode_t;

    logic                     vld_reg, vld_next;
    logic [7:0]               char_reg;
    logic                     eoi_reg;
    mode_t                    mode_reg, mode_next;
    head_t                    head_reg, head_next;
    logic [LW-1:0]            len_reg, len_next;
    logic [POSITION_BITS-1:0] cur_line_reg, cur_line_next;
    logic [POSITION_BITS-1:0] cur_col_reg, cur_col_next;
    logic [POSITION_BITS-1:0] tok_line_reg, tok_line_next;
    logic [POSITION_BITS-1:0] tok_col_reg, tok_col_next;

    logic                     in_accept;
    logic                     fire;
    logic [POSITION_BITS-1:0] line_adv, col_adv;
    logic [LW-1:0]            len_app;
    head_t                    head_app;
    logic [3:0]               len_short;
    token_kind_t              cur_special, cur_keyword;
    logic                     c_alpha, c_digit, c_punct, c_blank, c_bracket, c_quote;
    logic                     beg_emits;
    token_kind_t              beg_kind;
    mode_t                    beg_mode;
    logic                     emit_tok, tok_use_app, do_begin, emit_end;
    token_kind_t              tok_kind;
    token_t                   tok_r, beg_r, end_r;
    logic                     b_emit;

    function automatic logic [7:0] sat_len(input logic [LW-1:0] v);
        return (v > LW'(LEN_LIM)) ? 8'(LEN_LIM) : 8'(v);
    endfunction

    // Input register: a beat is taken when the slot is free or drains now
    assign chars.ready = !vld_reg || room;
    assign in_accept   = chars.valid && chars.ready;
    assign fire        = vld_reg && room;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_accept)
            vld_next = 1'b1;
        else if (fire)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            char_reg <= chars.character;
            eoi_reg  <= chars.end_of_input;
        end
    end

    // Character class and saturating position advance
    always_comb
    begin
        c_alpha   = is_alpha(char_reg);
        c_digit   = is_digit(char_reg);
        c_punct   = is_punct(char_reg);
        c_blank   = is_blank(char_reg);
        c_bracket = is_bracket(char_reg);
        c_quote   = (char_reg == CH_QUOTE);

        line_adv = cur_line_reg;
        col_adv  = cur_col_reg;
        if (char_reg == CH_LF)
        begin
            col_adv = '0;
            if (cur_line_reg != POS_MAX)
                line_adv = cur_line_reg + POSITION_BITS'(1);
        end else if (cur_col_reg != POS_MAX)
        begin
            col_adv = cur_col_reg + POSITION_BITS'(1);
        end
    end

    // Append path and matches on the open token
    always_comb
    begin
        len_app = len_reg;
        if (len_reg <= LW'(MAX_LENGTH))
            len_app = len_reg + LW'(1);
        head_app = head_reg;
        if (len_reg < LW'(8))
            head_app[len_reg[2:0]] = char_reg;
        len_short   = (len_reg > LW'(8)) ? 4'hF : 4'(len_reg);
        cur_special = special_kind(head_reg[0], head_reg[1],
                                   len_reg == LW'(1), len_reg == LW'(2));
        cur_keyword = keyword_kind(head_reg, len_short);
    end

    // Start of a new token on this character
    always_comb
    begin
        beg_mode  = MODE_IDLE;
        beg_emits = 1'b0;
        beg_kind  = KIND_ERROR;
        if (!c_blank)
        begin
            if (c_alpha)
                beg_mode = MODE_IDENT;
            else if (c_digit)
                beg_mode = MODE_NUMBER;
            else if (c_quote)
                beg_mode = MODE_STRING;
            else if (c_punct && !c_bracket)
                beg_mode = MODE_RUN;
            else
            begin
                beg_emits = 1'b1;
                if (c_bracket)
                    beg_kind = special_kind(char_reg, 8'h00, 1'b1, 1'b0);
            end
        end
    end

    // Token decisions and state update
    always_comb
    begin
        mode_next     = mode_reg;
        head_next     = head_reg;
        len_next      = len_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        emit_tok      = 1'b0;
        tok_use_app   = 1'b0;
        tok_kind      = KIND_ERROR;
        do_begin      = 1'b0;
        emit_end      = 1'b0;

        if (eoi_reg)
        begin
            // close any open token, then the end marker
            emit_tok  = (mode_reg != MODE_IDLE);
            emit_end  = 1'b1;
            mode_next = MODE_IDLE;
            case (mode_reg)
                MODE_IDENT:  tok_kind = cur_keyword;
                MODE_NUMBER: tok_kind = KIND_NUMBER;
                MODE_STRING: tok_kind = KIND_STRING;
                MODE_RUN:    tok_kind = cur_special;
                default:     tok_kind = KIND_ERROR;
            endcase
        end else
        begin
            cur_line_next = line_adv;
            cur_col_next  = col_adv;
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (c_alpha || c_digit)
                    begin
                        len_next  = len_app;
                        head_next = head_app;
                    end else
                    begin
                        emit_tok = 1'b1;
                        tok_kind = cur_keyword;
                        do_begin = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (c_digit)
                    begin
                        len_next  = len_app;
                        head_next = head_app;
                    end else
                    begin
                        emit_tok = 1'b1;
                        tok_kind = KIND_NUMBER;
                        do_begin = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    len_next  = len_app;
                    head_next = head_app;
                    if (c_quote)
                    begin
                        emit_tok    = 1'b1;
                        tok_use_app = 1'b1;
                        tok_kind    = KIND_STRING;
                        mode_next   = MODE_IDLE;
                    end
                end
                MODE_RUN:
                begin
                    if (c_punct)
                    begin
                        len_next  = len_app;
                        head_next = head_app;
                    end else if (cur_special != KIND_ERROR)
                    begin
                        emit_tok = 1'b1;
                        tok_kind = cur_special;
                        do_begin = 1'b1;
                    end else
                    begin
                        // failed run swallows the character that ended it
                        len_next    = len_app;
                        head_next   = head_app;
                        emit_tok    = 1'b1;
                        tok_use_app = 1'b1;
                        tok_kind    = KIND_ERROR;
                        mode_next   = MODE_IDLE;
                    end
                end
                default:
                begin
                    do_begin = 1'b1;
                end
            endcase

            if (do_begin)
            begin
                mode_next = beg_mode;
                if (!c_blank)
                begin
                    tok_line_next = line_adv;
                    tok_col_next  = col_adv;
                    head_next[0]  = char_reg;
                    len_next      = LW'(1);
                end
            end
        end
    end

    // Candidate results, packed in emission order
    always_comb
    begin
        tok_r.kind   = tok_kind;
        tok_r.line   = 16'(tok_line_reg);
        tok_r.column = 16'(tok_col_reg);
        tok_r.length = sat_len(tok_use_app ? len_app : len_reg);
        tok_r.last   = 1'b0;

        beg_r.kind   = beg_kind;
        beg_r.line   = 16'(line_adv);
        beg_r.column = 16'(col_adv);
        beg_r.length = 8'd1;
        beg_r.last   = 1'b0;

        end_r.kind   = KIND_END;
        end_r.line   = 16'(cur_line_reg);
        end_r.column = 16'(cur_col_reg);
        end_r.length = 8'd0;
        end_r.last   = 1'b0;

        b_emit = do_begin && beg_emits;

        push.count = fire ? (2'(emit_tok) + 2'(b_emit) + 2'(emit_end)) : 2'd0;
        push.tok0  = emit_tok ? tok_r : (b_emit ? beg_r : end_r);
        push.tok1  = (emit_tok && b_emit) ? beg_r : end_r;
        push.tok0.last = (push.count == 2'd1);
        push.tok1.last = 1'b1;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            len_reg      <= '0;
            cur_line_reg <= '0;
            cur_col_reg  <= '0;
            tok_line_reg <= '0;
            tok_col_reg  <= '0;
        end else if (fire)
        begin
            mode_reg     <= mode_next;
            len_reg      <= len_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            head_reg <= head_next;
    end

endmodule

### src/sct_result_queue.sv
// Four-entry shift queue that buffers tokens and drives the output channel.
module sct_result_queue
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push,
    output logic        room,
    sct_token_if.source tokens
);

    token_t                q_reg [QUEUE_DEPTH];
    token_t                q_next [QUEUE_DEPTH];
    logic [QCOUNT_W-1:0]   count_reg, count_next;
    logic [QCOUNT_W-1:0]   base;
    logic                  pop;

    // Two free entries cover the worst beat
    assign room = (count_reg <= QCOUNT_W'(QUEUE_DEPTH - 2));

    assign tokens.valid        = (count_reg != '0);
    assign tokens.token_kind   = q_reg[0].kind;
    assign tokens.start_line   = q_reg[0].line;
    assign tokens.start_column = q_reg[0].column;
    assign tokens.token_length = q_reg[0].length;
    assign tokens.last_of_run  = q_reg[0].last;

    assign pop  = tokens.valid && tokens.ready;
    assign base = count_reg - QCOUNT_W'(pop);

    // Shift out the head beat, then write new tokens at the tail
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && i < QUEUE_DEPTH - 1)
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
            if (push.count != 2'd0 && base == QCOUNT_W'(i))
                q_next[i] = push.tok0;
            if (push.count == 2'd2 && base + QCOUNT_W'(1) == QCOUNT_W'(i))
                q_next[i] = push.tok1;
        end
        count_next = base + QCOUNT_W'(push.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCOUNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("tokens pushed without room");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.count == 2'd0) |=> (count_reg == $past(count_reg) - QCOUNT_W'(1)))
        else $error("pop did not drain one entry");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.tok1.last && !push.tok0.last))
        else $error("last_of_run misplaced in token pair");
`endif

endmodule

### src/source_char_tokenizer_core.sv
// Top level of the streaming source tokenizer.
// One source byte (or an end-of-input mark) is taken per cycle on chars
// while chars.ready is high; it is registered, then, once the queue has
// room, classified and folded into the open token, and the tokens it
// completes (none, one or two) are written into the queue registers, from
// which they appear on tokens. Tokens leave one per cycle from a four-entry
// queue while the sink is ready; the input keeps streaming at one byte per
// cycle as long as the bytes complete at most one token each on average
// and the sink keeps up, and chars.ready drops only when fewer than two
// queue entries are free. Each token reports its start line (zero-based),
// start column (one-based) and a saturating length; the last token caused
// by a given byte carries last_of_run. No clearing pass follows reset.
module source_char_tokenizer_core
    import sct_pkg::*;
#(
    parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sct_char_if.sink    chars,
    sct_token_if.source tokens
);

    push_t push;
    logic  room;

    sct_lexer #(
        .MAX_LENGTH    (MAX_LENGTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .room  (room),
        .push  (push)
    );

    sct_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .tokens (tokens)
    );

endmodule

### sim/token_stream_check.sv
// Token stream checker: predicts the tokens of each accepted character beat and compares them.
module token_stream_check
    import sct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sct_char_if   chars,
    sct_token_if  tokens,
    output int    errors,
    output int    pending
);

    localparam int unsigned LEN_CAP = 255;
    localparam int unsigned POS_CAP = 65535;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_DIGITS,
        SCAN_QUOTED,
        SCAN_PUNCT
    } scan_t;

    string keywords [7] = '{"if", "else", "while", "function", "var", "printf", "return"};
    string operators [19] = '{"+", "-", "*", "/", "=", "==", "!=", "<", "<=", ">", ">=",
                              "&&", "||", "(", ")", "{", "}", ",", ";"};

    scan_t       scan;
    logic [7:0]  head [8];
    int unsigned tok_len;
    int unsigned line_now;
    int unsigned col_now;
    int unsigned tok_line;
    int unsigned tok_col;
    token_t      beat_tokens [$];
    token_t      expected_tokens [$];

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_mark(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    // At most two tokens per beat; length saturates
    function automatic void add_token(input token_kind_t k, input int unsigned ln,
                                      input int unsigned col, input int unsigned len);
        token_t t;
        if (beat_tokens.size() >= 2)
            return;
        t.kind   = k;
        t.line   = ln[15:0];
        t.column = col[15:0];
        t.length = (len > LEN_CAP) ? 8'(LEN_CAP) : len[7:0];
        t.last   = 1'b0;
        beat_tokens.push_back(t);
    endfunction

    function automatic void close_token(input token_kind_t k);
        add_token(k, tok_line, tok_col, tok_len);
    endfunction

    function automatic void open_token(input logic [7:0] c);
        tok_line = line_now;
        tok_col  = col_now;
        head[0]  = c;
        tok_len  = 1;
    endfunction

    function automatic void extend(input logic [7:0] c);
        if (tok_len < 8)
            head[tok_len] = c;
        if (tok_len <= LEN_CAP)
            tok_len++;
    endfunction

    // Operator lookup over a one- or two-character run
    function automatic token_kind_t op_kind();
        int i;
        if (tok_len != 1 && tok_len != 2)
            return KIND_ERROR;
        for (i = 0; i < 19; i++) begin
            if (operators[i].len() == tok_len && operators[i][0] == head[0] &&
                (tok_len == 1 || operators[i][1] == head[1]))
                return token_kind_t'(int'(KIND_PLUS) + i);
        end
        return KIND_ERROR;
    endfunction

    // Keywords match in full length only
    function automatic token_kind_t word_kind();
        int  k;
        int  i;
        bit  hit;
        for (k = 0; k < 7; k++) begin
            if (keywords[k].len() == tok_len) begin
                hit = 1'b1;
                for (i = 0; i < tok_len; i++)
                    if (keywords[k][i] != head[i])
                        hit = 1'b0;
                if (hit)
                    return token_kind_t'(int'(KIND_IF) + k);
            end
        end
        return KIND_IDENT;
    endfunction

    // Character outside any token: separator, new token or one-byte token
    function automatic void start_scan(input logic [7:0] c);
        scan = SCAN_IDLE;
        if (c == " " || c == "\t" || c == "\n")
            return;
        open_token(c);
        if (is_letter(c))
            scan = SCAN_WORD;
        else if (is_numeral(c))
            scan = SCAN_DIGITS;
        else if (c == "\"")
            scan = SCAN_QUOTED;
        else if (is_mark(c)) begin
            if (c == "(" || c == ")" || c == "{" || c == "}" || c == ";")
                close_token(op_kind());
            else
                scan = SCAN_PUNCT;
        end else
            close_token(KIND_ERROR);
    endfunction

    // One beat: update the scanner and queue the tokens it completes
    function automatic void scan_char(input logic [7:0] c, input logic eoi);
        token_kind_t k;
        beat_tokens.delete();
        if (eoi) begin
            case (scan)
                SCAN_WORD:   close_token(word_kind());
                SCAN_DIGITS: close_token(KIND_NUMBER);
                SCAN_QUOTED: close_token(KIND_STRING);
                SCAN_PUNCT:  close_token(op_kind());
                default:     ;
            endcase
            scan = SCAN_IDLE;
            add_token(KIND_END, line_now, col_now, 0);
        end else begin
            // position moves before the character is folded in
            if (c == "\n") begin
                if (line_now < POS_CAP)
                    line_now++;
                col_now = 0;
            end else if (col_now < POS_CAP)
                col_now++;
            case (scan)
                SCAN_WORD:
                    if (is_letter(c) || is_numeral(c))
                        extend(c);
                    else begin
                        close_token(word_kind());
                        start_scan(c);
                    end
                SCAN_DIGITS:
                    if (is_numeral(c))
                        extend(c);
                    else begin
                        close_token(KIND_NUMBER);
                        start_scan(c);
                    end
                SCAN_QUOTED:
                begin
                    extend(c);
                    if (c == "\"") begin
                        close_token(KIND_STRING);
                        scan = SCAN_IDLE;
                    end
                end
                SCAN_PUNCT:
                    if (is_mark(c))
                        extend(c);
                    else begin
                        k = op_kind();
                        if (k != KIND_ERROR) begin
                            close_token(k);
                            start_scan(c);
                        end else begin
                            // failed run swallows the terminating character
                            extend(c);
                            close_token(KIND_ERROR);
                            scan = SCAN_IDLE;
                        end
                    end
                default:
                    start_scan(c);
            endcase
        end
        if (beat_tokens.size() > 0)
            beat_tokens[beat_tokens.size() - 1].last = 1'b1;
        foreach (beat_tokens[i])
            expected_tokens.push_back(beat_tokens[i]);
    endfunction

    // Compare accepted tokens, then predict from the accepted character beat
    always @(posedge clk or negedge rst_n)
    begin
        token_t want;
        if (!rst_n) begin
            scan     = SCAN_IDLE;
            tok_len  = 0;
            line_now = 0;
            col_now  = 0;
            tok_line = 0;
            tok_col  = 0;
            expected_tokens.delete();
            pending  = 0;
        end else begin
            if (tokens.valid && tokens.ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: kind %0d line %0d column %0d",
                           tokens.token_kind, tokens.start_line, tokens.start_column);
                    errors++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (tokens.token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, actual %0d",
                               want.kind, tokens.token_kind);
                        errors++;
                    end
                    if (tokens.start_line !== want.line) begin
                        $error("start_line: expected %0d, actual %0d",
                               want.line, tokens.start_line);
                        errors++;
                    end
                    if (tokens.start_column !== want.column) begin
                        $error("start_column: expected %0d, actual %0d",
                               want.column, tokens.start_column);
                        errors++;
                    end
                    if (tokens.token_length !== want.length) begin
                        $error("token_length: expected %0d, actual %0d",
                               want.length, tokens.token_length);
                        errors++;
                    end
                    if (tokens.last_of_run !== want.last) begin
                        $error("last_of_run: expected %0d, actual %0d",
                               want.last, tokens.last_of_run);
                        errors++;
                    end
                end
            end
            if (chars.valid && chars.ready)
                scan_char(chars.character, chars.end_of_input);
            pending = expected_tokens.size();
        end
    end

endmodule

### sim/tb_source_char_tokenizer_core.sv
// Testbench top: clock, reset, character stimulus, token back-pressure and the verdict.
module tb_source_char_tokenizer_core;
    import sct_pkg::*;

    localparam int RANDOM_BEATS = 1000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   idle_on = 1'b1;
    int   n_fail;
    int   n_wait;
    int   sent;

    string words [7] = '{"if", "else", "while", "function", "var", "printf", "return"};
    string ops [19]  = '{"+", "-", "*", "/", "=", "==", "!=", "<", "<=", ">", ">=",
                         "&&", "||", "(", ")", "{", "}", ",", ";"};

    sct_char_if  chars ();
    sct_token_if tokens ();

    source_char_tokenizer_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .tokens (tokens)
    );

    token_stream_check CHK (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .tokens  (tokens),
        .errors  (n_fail),
        .pending (n_wait)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Token sink stalls at random while idling is on
    always @(posedge clk)
        tokens.ready <= !idle_on || ($urandom_range(99) >= 28);

    // One character beat; a random run of idle cycles may come in front of it
    task automatic put_beat(input logic [7:0] c, input logic eoi);
        while (idle_on && $urandom_range(99) < 28)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid        <= 1'b1;
        chars.character    <= c;
        chars.end_of_input <= eoi;
        do @(posedge clk); while (!chars.ready);
        sent++;
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_beat(s[i], 1'b0);
    endtask

    task automatic put_end();
        put_beat(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] any_letter();
        return $urandom_range(1) ? 8'($urandom_range(8'h7a, 8'h61))
                                 : 8'($urandom_range(8'h5a, 8'h41));
    endfunction

    function automatic logic [7:0] any_alnum();
        return ($urandom_range(3) == 0) ? 8'($urandom_range(8'h39, 8'h30)) : any_letter();
    endfunction

    function automatic logic [7:0] any_mark();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(47, 33));
            1:       return 8'($urandom_range(64, 58));
            2:       return 8'($urandom_range(96, 91));
            default: return 8'($urandom_range(126, 123));
        endcase
    endfunction

    function automatic logic [7:0] any_gap();
        case ($urandom_range(2))
            0:       return " ";
            1:       return "\t";
            default: return "\n";
        endcase
    endfunction

    // Mostly well-formed tokens with random content, some noise and broken runs
    task automatic put_random_token();
        int         pick;
        int         n;
        int         i;
        logic [7:0] c;
        pick = $urandom_range(99);
        // a rare token that can be long enough to saturate the length
        n = ($urandom_range(199) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 10);
        if (pick < 22) begin
            case ($urandom_range(5))
                0, 1: put_text(words[$urandom_range(6)]);
                2:
                begin
                    // keyword prefix that must not match
                    put_text(words[$urandom_range(6)]);
                    put_beat(any_alnum(), 1'b0);
                end
                default:
                begin
                    put_beat(any_letter(), 1'b0);
                    for (i = 1; i < n; i++)
                        put_beat(any_alnum(), 1'b0);
                end
            endcase
        end else if (pick < 34) begin
            for (i = 0; i < n; i++)
                put_beat(8'($urandom_range(8'h39, 8'h30)), 1'b0);
        end else if (pick < 44) begin
            put_beat("\"", 1'b0);
            for (i = 1; i < n; i++) begin
                c = 8'($urandom_range(255));
                put_beat((c == "\"") ? 8'h27 : c, 1'b0);
            end
            if ($urandom_range(7) == 0)
                put_end();
            else
                put_beat("\"", 1'b0);
        end else if (pick < 70) begin
            put_text(ops[$urandom_range(18)]);
        end else if (pick < 78) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                put_beat(any_mark(), 1'b0);
            if ($urandom_range(3) == 0)
                put_end();
            else
                put_beat(8'($urandom_range(255)), 1'b0);
        end else if (pick < 84) begin
            put_beat(8'($urandom_range(255)), 1'b0);
        end else if (pick < 87) begin
            put_end();
        end else begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                put_beat(any_gap(), 1'b0);
        end
        if ($urandom_range(1) == 0)
            put_beat(any_gap(), 1'b0);
    endtask

    // Stimulus and verdict
    initial
    begin
        int w;
        chars.valid        <= 1'b0;
        chars.character    <= 8'h00;
        chars.end_of_input <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: operators, brackets, keyword, string, failed runs, bad bytes
        put_text("if(a1>=9){\"s\"};");
        put_text("!?x");
        put_beat(8'hff, 1'b0);
        put_beat(8'h00, 1'b0);
        put_text("\t|");
        put_end();
        put_text("\"q");
        put_end();

        // random, with a long stretch without idling on either side
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            idle_on = !(sent >= 300 && sent < 550);
            put_random_token();
        end
        idle_on = 1'b1;
        put_end();
        chars.valid <= 1'b0;
        @(posedge clk);

        for (w = 0; w < 5000 && n_wait != 0; w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_fail == 0 && n_wait == 0)
            $display("source_char_tokenizer_core: match");
        else
            $display("source_char_tokenizer_core: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #12000000;
        $display("source_char_tokenizer_core: mismatch");
        $finish;
    end

endmodule
